// ===== hdl/pidc_pkg.sv =====
package pidc_pkg;

  // Register file layout of the configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KP             = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI             = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD             = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_LIMIT     = 3'd6;

  // Reset value of the drive and slew limits: 1000.0 in Q16.16.
  localparam logic [30:0] LIMIT_RESET = 31'd65536000;

  // Saturation bounds of a 32-bit signed value.
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Divider: 31 quotient bits after the overflow check, one bit per cycle.
  localparam int DIV_STEPS = 31;
  localparam int DIV_CNT_W = 5;

  // Request to the derivative divider.
  typedef struct packed {
    logic        start;
    logic        neg;
    logic [62:0] mag;
    logic [31:0] divisor;
  } div_req_t;

  // Response of the derivative divider.
  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return Q_MAX;
    end else if (v < -66'sd2147483648) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // Clamp a value to plus or minus a non-negative limit.
  function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = $signed({1'b0, lim});
    lo = -hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

// ===== hdl/pidc_if.sv =====
// Input sample channel: error and time step.
interface pidc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] error;
  logic        [31:0] dt;
  modport source (output valid, error, dt, input ready);
  modport sink (input valid, error, dt, output ready);
endinterface

// Output channel: limited drive value.
interface pidc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

// Configuration write channel.
interface pidc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pidc_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/pidc_div.sv =====
// Restoring divider for the derivative term. The magnitude of a Q32.32
// product is divided by the Q16.16 time step, truncating toward zero.
// A quotient of 2^31 or more saturates at once; otherwise one quotient
// bit is produced per cycle.
module pidc_div (
  input  logic               clk,
  input  logic               rst,
  input  pidc_pkg::div_req_t req,
  output pidc_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic [pidc_pkg::DIV_CNT_W-1:0] cnt;
  logic [31:0]                    rem;
  logic [30:0]                    sh;
  logic [31:0]                    divisor;
  logic                           neg;
  logic                           done;
  logic signed [31:0]             quot;

  logic [32:0]        trial;
  logic [32:0]        trial_sub;
  logic               ge;
  logic [31:0]        rem_next;
  logic [30:0]        sh_next;
  logic               ovf;
  logic signed [31:0] q_pos;

  // One restoring step: shift in the next numerator bit and try a subtract.
  always_comb begin
    trial     = {rem, sh[30]};
    trial_sub = trial - {1'b0, divisor};
    ge        = trial >= {1'b0, divisor};
    rem_next  = ge ? trial_sub[31:0] : trial[31:0];
    sh_next   = {sh[29:0], ge};
    q_pos     = $signed({1'b0, sh_next});
    ovf       = req.mag[62:31] >= req.divisor;
  end

  // Sequencing of the division.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (ovf) begin
          done <= 1'b1;
          quot <= req.neg ? pidc_pkg::Q_MIN : pidc_pkg::Q_MAX;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= neg ? -q_pos : q_pos;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt     <= '0;
      rem     <= req.mag[62:31];
      sh      <= req.mag[30:0];
      divisor <= req.divisor;
      neg     <= req.neg;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      rem <= rem_next;
      sh  <= sh_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

  // A new division is never requested while one is running.
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

  // The last step always reports completion in the next cycle.
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    busy && cnt == pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_STEPS - 1) && !req.start
      |=> done && !busy)
    else $error("divider missed completion");

  // Completion is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done held longer than one cycle");

endmodule

// ===== hdl/pid_with_clamps_and_slew_limit.sv =====
// Each accepted transaction steps through the states MDT, INT, PT, IT and DT, then DIV for
// a nonzero dt, then SUM and SLEW; an overflowing derivative quotient saturates at once.
// A new transaction is taken only in IDLE; one shared 33x33 multiplier forms four products
// in turn and a radix-2 divider forms the derivative term. An untaken result stalls the next.
// Reset clears gains, error and integral limits and all loop state to zero and
// sets the drive and slew limits to 1000.0.
module pid_with_clamps_and_slew_limit (
  input  logic        clk,
  input  logic        rst,
  pidc_in_if.sink     sample,
  pidc_out_if.source  result,
  pidc_cfg_if.sink    cfg
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MDT  = 4'd1;
  localparam logic [3:0] S_INT  = 4'd2;
  localparam logic [3:0] S_PT   = 4'd3;
  localparam logic [3:0] S_IT   = 4'd4;
  localparam logic [3:0] S_DT   = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_SLEW = 4'd8;

  // Configuration registers.
  logic signed [31:0] kp;
  logic signed [31:0] ki;
  logic signed [31:0] kd;
  logic [30:0]        error_limit;
  logic [30:0]        integral_limit;
  logic [30:0]        drive_limit;
  logic [30:0]        slew_limit;

  // Loop state.
  logic signed [31:0] integral;
  logic signed [31:0] prev_error;
  logic signed [31:0] prev_drive;

  // Sequencer and working registers.
  logic [3:0]         state;
  logic signed [31:0] e_q;
  logic [31:0]        dt_q;
  logic signed [31:0] diff;
  logic signed [65:0] prod;
  logic signed [33:0] acc;
  logic signed [31:0] dterm;
  logic signed [31:0] drv_c;
  logic               out_valid;
  logic signed [31:0] out_drive;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_mag;
  logic signed [31:0] prod_q;
  logic signed [32:0] step;
  logic signed [32:0] slew_s;
  logic signed [31:0] drive_slewed;
  logic               out_blocked;

  pidc_pkg::div_req_t div_req;
  pidc_pkg::div_rsp_t div_rsp;

  // Configuration writes; unknown indexes are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp             <= '0;
      ki             <= '0;
      kd             <= '0;
      error_limit    <= '0;
      integral_limit <= '0;
      drive_limit    <= pidc_pkg::LIMIT_RESET;
      slew_limit     <= pidc_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        pidc_pkg::REG_KP:             kp <= cfg.data;
        pidc_pkg::REG_KI:             ki <= cfg.data;
        pidc_pkg::REG_KD:             kd <= cfg.data;
        pidc_pkg::REG_ERROR_LIMIT:    error_limit <= cfg.data[30:0];
        pidc_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg.data[30:0];
        pidc_pkg::REG_DRIVE_LIMIT:    drive_limit <= cfg.data[30:0];
        pidc_pkg::REG_SLEW_LIMIT:     slew_limit <= cfg.data[30:0];
        default: begin
        end
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      S_MDT: begin
        mul_a = 33'(e_q);
        mul_b = $signed({1'b0, dt_q});
      end
      S_INT: begin
        mul_a = 33'(kp);
        mul_b = 33'(e_q);
      end
      S_PT: begin
        mul_a = 33'(ki);
        mul_b = 33'(integral);
      end
      S_IT: begin
        mul_a = 33'(kd);
        mul_b = 33'(diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Q16.16 rescale of the last product, divider request and slew limit.
  always_comb begin
    prod_q   = pidc_pkg::sat32(prod >>> 16);
    prod_mag = prod[65] ? -prod : prod;

    div_req.start   = (state == S_DT) && (dt_q != '0);
    div_req.neg     = prod[65];
    div_req.mag     = prod_mag[62:0];
    div_req.divisor = dt_q;

    step   = 33'(drv_c) - 33'(prev_drive);
    slew_s = $signed({2'b00, slew_limit});
    if (step > slew_s) begin
      drive_slewed = pidc_pkg::sat32(66'(prev_drive) + 66'(slew_s));
    end else if (step < -slew_s) begin
      drive_slewed = pidc_pkg::sat32(66'(prev_drive) - 66'(slew_s));
    end else begin
      drive_slewed = drv_c;
    end

    out_blocked = out_valid && !result.ready;
  end

  pidc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer, loop state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      integral   <= '0;
      prev_error <= '0;
      prev_drive <= '0;
    end else begin
      if (state == S_SLEW && !out_blocked) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            state <= S_MDT;
          end
        end
        S_MDT: begin
          state <= S_INT;
        end
        S_INT: begin
          integral <= pidc_pkg::clamp_sym(
                        pidc_pkg::sat32((prod >>> 16) + 66'(integral)),
                        integral_limit);
          state <= S_PT;
        end
        S_PT: begin
          state <= S_IT;
        end
        S_IT: begin
          state <= S_DT;
        end
        S_DT: begin
          state <= (dt_q == '0) ? S_SUM : S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_SLEW;
        end
        S_SLEW: begin
          if (!out_blocked) begin
            prev_drive <= drive_slewed;
            prev_error <= e_q;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        e_q  <= pidc_pkg::clamp_sym(sample.error, error_limit);
        dt_q <= sample.dt;
      end
      S_MDT: begin
        diff <= pidc_pkg::sat32(66'(e_q) - 66'(prev_error));
      end
      S_PT: begin
        acc <= 34'(prod_q);
      end
      S_IT: begin
        acc <= acc + 34'(prod_q);
      end
      S_DT: begin
        dterm <= '0;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          dterm <= div_rsp.quot;
        end
      end
      S_SUM: begin
        drv_c <= pidc_pkg::clamp_sym(pidc_pkg::sat32(66'(acc) + 66'(dterm)),
                                     drive_limit);
      end
      S_SLEW: begin
        if (!out_blocked) begin
          out_drive <= drive_slewed;
        end
      end
      default: begin
      end
    endcase
  end

  assign sample.ready = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.drive = out_drive;

  // An accepted transaction always starts the multiply sequence.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> state == S_MDT)
    else $error("accepted sample did not start processing");

  // The divider is only waited on for a nonzero time step.
  a_div_dt: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dt_q != '0)
    else $error("waiting on divider with zero dt");

  // Leaving the slew stage always presents a result.
  a_slew_out: assert property (@(posedge clk) disable iff (rst)
    state == S_SLEW && !out_blocked |=> result.valid && state == S_IDLE)
    else $error("result not presented after slew stage");

  // No new sample is taken while the divider is being waited on.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> !sample.ready)
    else $error("sample accepted during division");

endmodule

// ===== tb/pidc_drive_checker.sv =====
`timescale 1ns / 100ps

// Watches the sample, result and register channels of the PID block. It keeps
// its own copy of the loop state and settings, predicts the drive for every
// accepted sample, and compares each returned drive with the oldest prediction.
module pidc_drive_checker (
  input  logic clk,
  input  logic rst,
  pidc_in_if   sample,
  pidc_out_if  result,
  pidc_cfg_if  cfg,
  output int   mismatches,
  output int   outstanding
);
  import pidc_pkg::*;

  // Shadow copy of the gains and limits.
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic        [30:0] lim_err;
  logic        [30:0] lim_int;
  logic        [30:0] lim_drv;
  logic        [30:0] lim_slew;

  // Loop state carried from one sample to the next.
  logic signed [31:0] integ;
  logic signed [31:0] prev_err;
  logic signed [31:0] prev_drv;

  // Drives predicted but not yet returned, oldest first.
  logic signed [31:0] drive_q[$];

  // Saturate an exact value to the 32-bit signed range.
  function automatic logic signed [31:0] fit32(input longint v);
    if (v > longint'(Q_MAX)) begin
      return Q_MAX;
    end else if (v < longint'(Q_MIN)) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // Clamp to plus or minus a non-negative limit.
  function automatic longint hold_within(input longint v, input logic [30:0] lim);
    longint bound;
    bound = lim;
    if (v > bound) begin
      return bound;
    end else if (v < -bound) begin
      return -bound;
    end
    return v;
  endfunction

  // Run one control step and return the limited drive.
  function automatic logic signed [31:0] next_drive(input logic signed [31:0] err_in,
                                                    input logic [31:0] step_dt);
    longint e;
    longint t;
    longint acc;
    longint p_part;
    longint i_part;
    longint d_part;
    longint u;
    longint delta;
    longint slew;
    e = hold_within(longint'(err_in), lim_err);
    t = longint'({32'd0, step_dt});
    slew = lim_slew;

    // The integral gains floor(e * dt / 2^16) and is then clamped.
    acc = fit32(longint'(integ) + ((e * t) >>> 16));
    acc = hold_within(acc, lim_int);

    // Products are Q32.32 and are brought back to Q16.16 by a floor shift.
    p_part = fit32((longint'(gain_p) * e) >>> 16);
    i_part = fit32((longint'(gain_i) * acc) >>> 16);

    // A zero time step turns the derivative term off.
    if (t == 0) begin
      d_part = 0;
    end else begin
      d_part = fit32((longint'(gain_d) * fit32(e - longint'(prev_err))) / t);
    end

    u = hold_within(fit32(p_part + i_part + d_part), lim_drv);

    // The slew limit works on the exact step from the previous drive.
    delta = u - longint'(prev_drv);
    if (delta > slew) begin
      u = fit32(longint'(prev_drv) + slew);
    end else if (delta < -slew) begin
      u = fit32(longint'(prev_drv) - slew);
    end

    integ = acc[31:0];
    prev_err = e[31:0];
    prev_drv = u[31:0];
    return u[31:0];
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (rst) begin
      gain_p = '0;
      gain_i = '0;
      gain_d = '0;
      lim_err = '0;
      lim_int = '0;
      lim_drv = LIMIT_RESET;
      lim_slew = LIMIT_RESET;
      integ = '0;
      prev_err = '0;
      prev_drv = '0;
      drive_q.delete();
    end else begin
      // A register write updates the shadow settings; unknown indexes do nothing.
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_KP: gain_p = cfg.data;
          REG_KI: gain_i = cfg.data;
          REG_KD: gain_d = cfg.data;
          REG_ERROR_LIMIT: lim_err = cfg.data[30:0];
          REG_INTEGRAL_LIMIT: lim_int = cfg.data[30:0];
          REG_DRIVE_LIMIT: lim_drv = cfg.data[30:0];
          REG_SLEW_LIMIT: lim_slew = cfg.data[30:0];
          default: ;
        endcase
      end

      // Each returned drive is checked against the oldest prediction.
      if (result.valid && result.ready) begin
        if (drive_q.size() == 0) begin
          $error("drive returned with no transaction pending: got %0d", result.drive);
          mismatches++;
        end else begin
          want = drive_q.pop_front();
          if (result.drive !== want) begin
            $error("drive mismatch: expected %0d, got %0d", want, result.drive);
            mismatches++;
          end
        end
      end

      // Each accepted sample advances the predicted loop state.
      if (sample.valid && sample.ready) begin
        drive_q.push_back(next_drive(sample.error, sample.dt));
      end
    end
    outstanding = drive_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam logic [pidc_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 106;

  logic clk;
  logic rst;
  int mismatches;
  int outstanding;
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;

  pidc_in_if  in_ch ();
  pidc_out_if out_ch ();
  pidc_cfg_if cfg_ch ();

  pid_with_clamps_and_slew_limit dut (
    .clk    (clk),
    .rst    (rst),
    .sample (in_ch),
    .result (out_ch),
    .cfg    (cfg_ch)
  );

  pidc_drive_checker chk (
    .clk         (clk),
    .rst         (rst),
    .sample      (in_ch),
    .result      (out_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  // Random gain: mostly within +-4.0, sometimes zero or any 32-bit value.
  function automatic logic [31:0] draw_gain();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // Random limit: mostly 1.0 to 256.0, with zero, the maximum and wild values.
  function automatic logic [31:0] draw_limit();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(32'h0001_0000, 32'h0100_0000);
    endcase
  endfunction

  // Random error sample: mostly within +-16.0, sometimes any 32-bit value.
  function automatic logic [31:0] draw_error();
    if ($urandom_range(0, 5) == 0) begin
      return $urandom;
    end
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  // Random time step: mostly up to 2.0, with zero and any 32-bit value.
  function automatic logic [31:0] draw_dt();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  // One register write; valid stays high so a following write can go at once.
  task automatic write_reg(input logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the full register set, then release the channel.
  task automatic load_settings(input logic [31:0] p, input logic [31:0] i,
                               input logic [31:0] d, input logic [31:0] el,
                               input logic [31:0] il, input logic [31:0] dl,
                               input logic [31:0] sl);
    write_reg(pidc_pkg::REG_KP, p);
    write_reg(pidc_pkg::REG_KI, i);
    write_reg(pidc_pkg::REG_KD, d);
    write_reg(pidc_pkg::REG_ERROR_LIMIT, el);
    write_reg(pidc_pkg::REG_INTEGRAL_LIMIT, il);
    write_reg(pidc_pkg::REG_DRIVE_LIMIT, dl);
    write_reg(pidc_pkg::REG_SLEW_LIMIT, sl);
    cfg_ch.valid = 1'b0;
  endtask

  // Offer one sample after a random gap, none when no_idle is set; valid stays high after acceptance.
  task automatic offer_sample(input logic [31:0] err, input logic [31:0] step_dt);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.error = err;
    in_ch.dt = step_dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted drive has come back.
  task automatic wait_for_drives();
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Result side: random stalls per transaction, plus one long hold on request.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus: directed corner cases, then randomized phases.
  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.error = '0;
    in_ch.dt = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: the zero error limit forces every error to zero.
    offer_sample(32'h7fff_ffff, 32'h0001_0000);
    offer_sample(32'h8000_0000, 32'hffff_ffff);
    wait_for_drives();

    // Moderate gains with all limits wide open.
    load_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    offer_sample(32'h7fff_ffff, 32'h0001_0000);
    offer_sample(32'h8000_0000, 32'hffff_ffff);
    offer_sample(32'h0000_0000, 32'h0000_0000);
    offer_sample(32'hffff_ffff, 32'h0000_0001);
    offer_sample(32'h0000_0001, 32'h0000_0001);
    offer_sample(32'h1234_5678, 32'h0000_0000);
    offer_sample(32'hffff_0000, 32'h0001_0000);
    wait_for_drives();

    // Extreme gains drive every stage into saturation; the small slew limit
    // holds the drive back. The error limit write also sets the unused top bit.
    load_settings(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_0000);
    offer_sample(32'h7fff_ffff, 32'h0000_0001);
    offer_sample(32'h8000_0000, 32'hffff_ffff);
    offer_sample(32'h4000_0000, 32'h7fff_ffff);
    offer_sample(32'h8000_0000, 32'h0000_0001);
    wait_for_drives();

    // A lowered drive limit: the slewed drive may stay outside the clamp.
    load_settings(32'h0004_0000, 32'h0000_0000, 32'h0000_0000, 32'h0010_0000,
                  32'h0010_0000, 32'h0001_0000, 32'h0000_8000);
    offer_sample(32'h7fff_ffff, 32'h0000_0001);
    offer_sample(32'h0000_0000, 32'h0000_0000);
    wait_for_drives();

    // A write to an unused index must leave the settings alone.
    write_reg(REG_NONE, 32'hffff_ffff);
    cfg_ch.valid = 1'b0;
    offer_sample(32'h0008_0000, 32'h0001_0000);
    wait_for_drives();

    // Zero limits force error, integral and clamped drive to zero; the zero slew limit holds the output.
    load_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    offer_sample(32'h7fff_ffff, 32'hffff_ffff);
    offer_sample(32'h8000_0000, 32'h0000_0001);
    wait_for_drives();

    // Random phases, each with fresh settings loaded while the block is idle.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_for_drives();
      load_settings(draw_gain(), draw_gain(), draw_gain(), draw_limit(),
                    draw_limit(), draw_limit(), draw_limit());
      no_idle = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 10) begin
          hold_req = 1'b1;
        end
        if (ph == 5 && n == 50) begin
          wait_for_drives();
        end
        offer_sample(draw_error(), draw_dt());
      end
      no_idle = 1'b0;
    end

    // Let the last drives come back, then give the verdict.
    wait_for_drives();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pidc_pkg.sv
hdl/pidc_if.sv
hdl/pidc_div.sv
hdl/pid_with_clamps_and_slew_limit.sv
tb/pidc_drive_checker.sv
tb/tb.sv
